// ----- hw/rtl/pfa_pkg.sv -----
package pfa_pkg;

  localparam int FRAMES    = 64;
  localparam int PROCESSES = 16;
  localparam int MAX_PAGES = 64;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PID_W   = $clog2(PROCESSES);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int COUNT_W = FRAME_W + 1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_INUSE    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_NOCFG    = 3'd5;
  localparam logic [2:0] ST_NOFRAMES = 3'd6;

  // process states
  localparam logic [1:0] PS_ABSENT  = 2'd0;
  localparam logic [1:0] PS_RUNNING = 2'd1;
  localparam logic [1:0] PS_HALTED  = 2'd2;

  // opcodes
  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_HALT  = 1'b1;

  // register indexes
  localparam logic REG_MEMORY = 1'b0;
  localparam logic REG_PAGE   = 1'b1;

endpackage

// ----- hw/rtl/page_frame_allocator_top.sv -----
// Page frame allocator. Frames come from a FIFO free list held in a registered-read memory;
// each process's frames are kept in a page table memory, and each frame's fill byte count in a
// third memory. A configuration write rebuilds the list: a sweep writes the frame numbers
// while a 7-step shared divider works out memory_bytes / page_bytes; no item is taken during
// the sweep. An admit runs the divider once per segment, makes its checks and then pops one
// frame per pass through its read and write states, one result each, while results are taken.
// A halt walks the page table, reading each frame number and then its fill before it emits,
// one result each. An error result is registered from the error state, entered from idle for a
// halt or the early admit checks, and after the divider and checks for an empty segment or a
// full list. A result held by the receiver stalls the walk. Items are handled one at a time; a
// waiting result does not stop the next item from being accepted.
module page_frame_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_process_id,
  input  logic [19:0] in_text_bytes,
  input  logic [19:0] in_data_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_process_echo,
  output logic [5:0]  out_frame_number,
  output logic [5:0]  out_page_index,
  output logic [15:0] out_fill_bytes,
  output logic        out_segment_kind,
  output logic        out_freed,
  output logic [2:0]  out_status,
  output logic        out_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_REBUILD, S_DIV, S_CHK, S_A_RD, S_A_WR, S_H_RD, S_H_FF, S_H_EM, S_ERR
  } state_t;

  state_t state_r;

  logic [20:0] mem_bytes_r;
  logic [15:0] page_bytes_r;
  logic        frames_zero_r;
  logic [1:0]  proc_status_r [pfa_pkg::PROCESSES];
  logic [6:0]  proc_count_r  [pfa_pkg::PROCESSES];
  logic [5:0]  free_head_r;
  logic [6:0]  free_count_r;
  logic [5:0]  sw_r;

  logic        div_act_r;
  logic [20:0] div_rem_r;
  logic [6:0]  div_q_r;
  logic        div_ovf_r;
  logic [2:0]  div_k_r;

  logic [3:0]  pid_r;
  logic [19:0] dlen_r;
  logic [7:0]  tp_r, dp_r;
  logic        tbig_r, dbig_r;
  logic [15:0] tfill_r, dfill_r;
  logic        seg_r;
  logic [5:0]  pg_r;
  logic [5:0]  k_r;
  logic [6:0]  hn_r;
  logic [2:0]  err_r;

  logic        out_valid_r;
  logic [3:0]  out_pid_r;
  logic [5:0]  out_frame_r, out_page_r;
  logic [15:0] out_fill_r;
  logic        out_seg_r, out_freed_r, out_last_r;
  logic [2:0]  out_status_r;

  // memories
  logic [5:0]  free_fifo [pfa_pkg::FRAMES];
  logic [15:0] frame_fill [pfa_pkg::FRAMES];
  logic [5:0]  proc_pages [pfa_pkg::PROCESSES * pfa_pkg::MAX_PAGES];
  logic [5:0]  fifo_q, pages_q;
  logic [15:0] fill_q;

  logic        can_emit;
  logic [20:0] mem_new;
  logic [15:0] page_new;
  logic        cfg_ovf;
  logic [21:0] div_shift;
  logic        div_ge;
  logic [20:0] div_rem_step;
  logic [6:0]  div_q_step;
  logic [7:0]  seg_pages;
  logic [15:0] seg_fill;
  logic [6:0]  cfg_frames;
  logic        dlen_ovf, tlen_ovf;
  logic [8:0]  total;
  logic [7:0]  np_cur;
  logic        last_in_seg;
  logic [15:0] fill_cur;
  logic        alloc_we, push_we, sweep_we;
  logic [5:0]  fifo_waddr;
  logic [5:0]  fifo_wdata;

  assign can_emit = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign mem_new  = (cfg_we && cfg_index == pfa_pkg::REG_MEMORY) ? cfg_data : mem_bytes_r;
  assign page_new = (cfg_we && cfg_index == pfa_pkg::REG_PAGE) ? cfg_data[15:0] : page_bytes_r;
  assign cfg_ovf  = {2'b00, mem_new[20:7]} >= page_new;
  assign tlen_ovf = {3'b000, in_text_bytes[19:7]} >= page_bytes_r;
  assign dlen_ovf = {3'b000, dlen_r[19:7]} >= page_bytes_r;

  // one restoring step: quotient bit k
  assign div_shift    = {6'd0, page_bytes_r} << div_k_r;
  assign div_ge       = {1'b0, div_rem_r} >= div_shift;
  assign div_rem_step = div_ge ? (div_rem_r - div_shift[20:0]) : div_rem_r;
  assign div_q_step   = div_q_r | (div_ge ? (7'd1 << div_k_r) : 7'd0);
  assign seg_pages    = {1'b0, div_q_step} + {7'd0, (div_rem_step != 21'd0)};
  assign seg_fill     = (div_rem_step != 21'd0) ? div_rem_step[15:0] : page_bytes_r;

  assign cfg_frames = (page_bytes_r == 16'd0) ? 7'd0 :
                      (div_ovf_r || div_q_r[6]) ? 7'd64 : {1'b0, div_q_r[5:0]};

  assign total       = {1'b0, tp_r} + {1'b0, dp_r};
  assign np_cur      = seg_r ? dp_r : tp_r;
  assign last_in_seg = ({2'b00, pg_r} + 8'd1) == np_cur;
  assign fill_cur    = last_in_seg ? (seg_r ? dfill_r : tfill_r) : page_bytes_r;

  assign alloc_we   = (state_r == S_A_WR) && can_emit;
  assign push_we    = (state_r == S_H_EM) && can_emit && (free_count_r < 7'd64);
  assign sweep_we   = (state_r == S_REBUILD);
  assign fifo_waddr = sweep_we ? sw_r : (free_head_r + free_count_r[5:0]);
  assign fifo_wdata = sweep_we ? sw_r : pages_q;

  always_ff @(posedge clk) begin
    if (sweep_we || push_we) begin
      free_fifo[fifo_waddr] <= fifo_wdata;
    end
    fifo_q <= free_fifo[free_head_r];
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      frame_fill[fifo_q] <= fill_cur;
    end
    fill_q <= frame_fill[pages_q];
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      proc_pages[{pid_r, k_r}] <= fifo_q;
    end
    pages_q <= proc_pages[{pid_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      mem_bytes_r   <= '0;
      page_bytes_r  <= '0;
      frames_zero_r <= 1'b1;
      free_head_r   <= '0;
      free_count_r  <= '0;
      div_act_r     <= 1'b0;
      for (int i = 0; i < pfa_pkg::PROCESSES; i++) begin
        proc_status_r[i] <= pfa_pkg::PS_ABSENT;
        proc_count_r[i]  <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pid_r  <= in_process_id;
            dlen_r <= in_data_bytes;
            k_r    <= '0;
            if (in_opcode == pfa_pkg::OP_HALT) begin
              if (proc_status_r[in_process_id] != pfa_pkg::PS_RUNNING ||
                  proc_count_r[in_process_id] == 7'd0) begin
                err_r   <= pfa_pkg::ST_UNKNOWN;
                state_r <= S_ERR;
              end else begin
                hn_r    <= proc_count_r[in_process_id];
                state_r <= S_H_RD;
              end
            end else if (page_bytes_r == 16'd0) begin
              err_r   <= pfa_pkg::ST_NOCFG;
              state_r <= S_ERR;
            end else if (frames_zero_r) begin
              err_r   <= pfa_pkg::ST_NOFRAMES;
              state_r <= S_ERR;
            end else if (proc_status_r[in_process_id] == pfa_pkg::PS_RUNNING) begin
              err_r   <= pfa_pkg::ST_INUSE;
              state_r <= S_ERR;
            end else begin
              div_rem_r <= {1'b0, in_text_bytes};
              div_q_r   <= '0;
              div_ovf_r <= tlen_ovf;
              div_k_r   <= 3'd6;
              seg_r     <= 1'b0;
              state_r   <= S_DIV;
            end
          end
        end
        S_REBUILD: begin
          if (div_act_r) begin
            div_rem_r <= div_rem_step;
            div_q_r   <= div_q_step;
            div_k_r   <= div_k_r - 3'd1;
            if (div_k_r == 3'd0) div_act_r <= 1'b0;
          end
          sw_r <= sw_r + 6'd1;
          if (sw_r == 6'(pfa_pkg::FRAMES - 1)) begin
            free_head_r   <= '0;
            free_count_r  <= cfg_frames;
            frames_zero_r <= (cfg_frames == 7'd0);
            state_r       <= S_IDLE;
          end
        end
        S_DIV: begin
          div_rem_r <= div_rem_step;
          div_q_r   <= div_q_step;
          div_k_r   <= div_k_r - 3'd1;
          if (div_k_r == 3'd0) begin
            if (!seg_r) begin
              tp_r      <= seg_pages;
              tbig_r    <= div_ovf_r;
              tfill_r   <= seg_fill;
              div_rem_r <= {1'b0, dlen_r};
              div_q_r   <= '0;
              div_ovf_r <= dlen_ovf;
              div_k_r   <= 3'd6;
              seg_r     <= 1'b1;
            end else begin
              dp_r    <= seg_pages;
              dbig_r  <= div_ovf_r;
              dfill_r <= seg_fill;
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if ((!tbig_r && tp_r == 8'd0) || (!dbig_r && dp_r == 8'd0)) begin
            err_r   <= pfa_pkg::ST_EMPTY;
            state_r <= S_ERR;
          end else if (tbig_r || dbig_r || total > {2'b00, free_count_r} ||
                       total > 9'(pfa_pkg::MAX_PAGES)) begin
            err_r   <= pfa_pkg::ST_FULL;
            state_r <= S_ERR;
          end else begin
            seg_r   <= 1'b0;
            pg_r    <= '0;
            state_r <= S_A_RD;
          end
        end
        S_A_RD: state_r <= S_A_WR;
        S_A_WR: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_pid_r    <= pid_r;
            out_frame_r  <= fifo_q;
            out_page_r   <= pg_r;
            out_fill_r   <= fill_cur;
            out_seg_r    <= seg_r;
            out_freed_r  <= 1'b0;
            out_status_r <= pfa_pkg::ST_OK;
            out_last_r   <= seg_r && last_in_seg;
            free_head_r  <= free_head_r + 6'd1;
            free_count_r <= free_count_r - 7'd1;
            k_r          <= k_r + 6'd1;
            if (seg_r && last_in_seg) begin
              proc_count_r[pid_r]  <= total[6:0];
              proc_status_r[pid_r] <= pfa_pkg::PS_RUNNING;
              state_r              <= S_IDLE;
            end else begin
              if (last_in_seg) begin
                seg_r <= 1'b1;
                pg_r  <= '0;
              end else begin
                pg_r <= pg_r + 6'd1;
              end
              state_r <= S_A_RD;
            end
          end
        end
        S_H_RD: state_r <= S_H_FF;
        S_H_FF: state_r <= S_H_EM;
        S_H_EM: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_pid_r    <= pid_r;
            out_frame_r  <= pages_q;
            out_page_r   <= '0;
            out_fill_r   <= fill_q;
            out_seg_r    <= 1'b0;
            out_freed_r  <= 1'b1;
            out_status_r <= pfa_pkg::ST_OK;
            out_last_r   <= ({1'b0, k_r} + 7'd1) == hn_r;
            if (free_count_r < 7'd64) free_count_r <= free_count_r + 7'd1;
            k_r <= k_r + 6'd1;
            if (({1'b0, k_r} + 7'd1) == hn_r) begin
              proc_count_r[pid_r]  <= '0;
              proc_status_r[pid_r] <= pfa_pkg::PS_HALTED;
              state_r              <= S_IDLE;
            end else begin
              state_r <= S_H_RD;
            end
          end
        end
        S_ERR: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_pid_r    <= pid_r;
            out_frame_r  <= '0;
            out_page_r   <= '0;
            out_fill_r   <= '0;
            out_seg_r    <= 1'b0;
            out_freed_r  <= 1'b0;
            out_status_r <= err_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // a write restarts the rebuild and forgets every process
      if (cfg_we) begin
        if (cfg_index == pfa_pkg::REG_MEMORY) mem_bytes_r <= cfg_data;
        else page_bytes_r <= cfg_data[15:0];
        for (int i = 0; i < pfa_pkg::PROCESSES; i++) begin
          proc_status_r[i] <= pfa_pkg::PS_ABSENT;
          proc_count_r[i]  <= '0;
        end
        div_rem_r <= mem_new;
        div_q_r   <= '0;
        div_ovf_r <= cfg_ovf;
        div_k_r   <= 3'd6;
        div_act_r <= 1'b1;
        sw_r      <= '0;
        state_r   <= S_REBUILD;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_process_echo = out_pid_r;
  assign out_frame_number = out_frame_r;
  assign out_page_index   = out_page_r;
  assign out_fill_bytes   = out_fill_r;
  assign out_segment_kind = out_seg_r;
  assign out_freed        = out_freed_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= 7'd64)
    else $error("free count above frame total");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_WR) |-> (free_count_r != 7'd0))
    else $error("frame popped from empty list");

  a_halt_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_H_EM && can_emit && ({1'b0, k_r} + 7'd1) == hn_r && !cfg_we)
      |=> (proc_status_r[pid_r] == pfa_pkg::PS_HALTED && proc_count_r[pid_r] == 7'd0))
    else $error("halted process not cleared");

endmodule

// ----- tb/page_frame_allocator_top_tb.sv -----
module page_frame_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  pid;
    logic [5:0]  frame;
    logic [5:0]  page;
    logic [15:0] fill;
    logic        seg;
    logic        freed;
    logic [2:0]  status;
    logic        last;
  } frame_result_t;

  class frame_scoreboard;
    frame_result_t pending_q[$];
    int            errors;
    logic [20:0]   mem_bytes;
    logic [15:0]   pg_bytes;
    logic [5:0]    free_list[pfa_pkg::FRAMES];
    int            head, count;
    logic [15:0]   fill_of[pfa_pkg::FRAMES];
    logic [5:0]    owned[pfa_pkg::PROCESSES][pfa_pkg::MAX_PAGES];
    int            owned_cnt[pfa_pkg::PROCESSES];
    logic [1:0]    proc_state[pfa_pkg::PROCESSES];

    function new();
      errors = 0;
      mem_bytes = '0;
      pg_bytes = '0;
      head = 0;
      count = 0;
      foreach (owned_cnt[i]) begin
        owned_cnt[i] = 0;
        proc_state[i] = pfa_pkg::PS_ABSENT;
      end
    endfunction

    function int frame_total();
      int n;
      if (pg_bytes == 0) return 0;
      n = mem_bytes / pg_bytes;
      return (n > pfa_pkg::FRAMES) ? pfa_pkg::FRAMES : n;
    endfunction

    function void write_reg(logic idx, logic [20:0] v);
      int n;
      if (idx == pfa_pkg::REG_MEMORY) mem_bytes = v;
      else pg_bytes = v[15:0];
      n = frame_total();
      head = 0;
      for (int i = 0; i < n; i++) free_list[i] = i[5:0];
      count = n;
      foreach (owned_cnt[i]) begin
        owned_cnt[i] = 0;
        proc_state[i] = pfa_pkg::PS_ABSENT;
      end
    endfunction

    function void push(int pid, int frame, int page, int fill, int seg, int freed,
                       logic [2:0] st, int last);
      frame_result_t r;
      r.pid = pid[3:0];
      r.frame = frame[5:0];
      r.page = page[5:0];
      r.fill = fill[15:0];
      r.seg = seg[0];
      r.freed = freed[0];
      r.status = st;
      r.last = last[0];
      pending_q.insert(pending_q.size(), r);
    endfunction

    function int pages_of(int len);
      return (len + pg_bytes - 1) / pg_bytes;
    endfunction

    function void note(logic op, logic [3:0] pid_v, logic [19:0] tlen, logic [19:0] dlen);
      int pid, n, f, tp, dp, total, k, np, len, fl;
      pid = pid_v;
      if (op == pfa_pkg::OP_HALT) begin
        n = owned_cnt[pid];
        if (proc_state[pid] != pfa_pkg::PS_RUNNING || n == 0) begin
          push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_UNKNOWN, 1);
          return;
        end
        for (int i = 0; i < n; i++) begin
          f = owned[pid][i];
          if (count < pfa_pkg::FRAMES) begin
            free_list[(head + count) % pfa_pkg::FRAMES] = f[5:0];
            count++;
          end
          push(pid, f, 0, fill_of[f], 0, 1, pfa_pkg::ST_OK, i + 1 == n);
        end
        owned_cnt[pid] = 0;
        proc_state[pid] = pfa_pkg::PS_HALTED;
        return;
      end
      if (pg_bytes == 0) begin
        push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_NOCFG, 1);
        return;
      end
      if (frame_total() == 0) begin
        push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_NOFRAMES, 1);
        return;
      end
      if (proc_state[pid] == pfa_pkg::PS_RUNNING) begin
        push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_INUSE, 1);
        return;
      end
      tp = pages_of(tlen);
      dp = pages_of(dlen);
      if (tp == 0 || dp == 0) begin
        push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_EMPTY, 1);
        return;
      end
      total = tp + dp;
      if (total > count || total > pfa_pkg::MAX_PAGES) begin
        push(pid, 0, 0, 0, 0, 0, pfa_pkg::ST_FULL, 1);
        return;
      end
      k = 0;
      for (int s = 0; s < 2; s++) begin
        np = (s == 0) ? tp : dp;
        len = (s == 0) ? tlen : dlen;
        for (int i = 0; i < np; i++) begin
          f = free_list[head];
          fl = (i + 1 < np) ? pg_bytes : len - (np - 1) * pg_bytes;
          head = (head + 1) % pfa_pkg::FRAMES;
          count--;
          fill_of[f] = fl[15:0];
          owned[pid][k] = f[5:0];
          push(pid, f, i, fl, s, 0, pfa_pkg::ST_OK, k + 1 == total);
          k++;
        end
      end
      owned_cnt[pid] = total;
      proc_state[pid] = pfa_pkg::PS_RUNNING;
    endfunction

    function void check(frame_result_t a);
      frame_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result pid %0d frame %0d status %0d",
                 $time, a.pid, a.frame, a.status);
        errors++;
        return;
      end
      e = pending_q[0];
      pending_q.delete(0);
      if (e !== a) begin
        $display("%0t: mismatch exp pid %0d frm %0d pg %0d fill %0d seg %0d fr %0d st %0d l %0d",
                 $time, e.pid, e.frame, e.page, e.fill, e.seg, e.freed, e.status, e.last);
        $display("%0t:          act pid %0d frm %0d pg %0d fill %0d seg %0d fr %0d st %0d l %0d",
                 $time, a.pid, a.frame, a.page, a.fill, a.seg, a.freed, a.status, a.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we, cfg_index;
  logic [20:0] cfg_data;
  logic        in_valid, in_ready, in_opcode;
  logic [3:0]  in_process_id;
  logic [19:0] in_text_bytes, in_data_bytes;
  logic        out_valid, out_ready;
  logic [3:0]  out_process_echo;
  logic [5:0]  out_frame_number, out_page_index;
  logic [15:0] out_fill_bytes;
  logic        out_segment_kind, out_freed, out_last;
  logic [2:0]  out_status;

  frame_scoreboard sb;
  bit burst;
  bit hold_req;

  page_frame_allocator_top dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("page_frame_allocator_top_tb: done, errors");
    $finish;
  end

  task automatic send_item(logic op, logic [3:0] pid, logic [19:0] t, logic [19:0] d);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= op;
    in_process_id <= pid;
    in_text_bytes <= t;
    in_data_bytes <= d;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note(op, pid, t, d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [20:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic setup(logic [20:0] mem, logic [15:0] pg);
    drain();
    write_cfg(pfa_pkg::REG_MEMORY, mem);
    write_cfg(pfa_pkg::REG_PAGE, {5'd0, pg});
  endtask

  // pages drawn from 1..4 so the free list turns over often
  function automatic logic [19:0] seg_len(int pg);
    int k, lo, hi;
    k = $urandom_range(1, 4);
    lo = (k - 1) * pg + 1;
    hi = k * pg;
    if (hi > 20'hFFFFF) hi = 20'hFFFFF;
    if (lo > hi) lo = hi;
    return 20'($urandom_range(lo, hi));
  endfunction

  task automatic random_item();
    int running[$];
    int pid;
    foreach (sb.proc_state[i])
      if (sb.proc_state[i] == pfa_pkg::PS_RUNNING) running.insert(running.size(), i);
    if ($urandom_range(0, 4) == 0) begin
      send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                20'($urandom()), 20'($urandom()));
    end else if (running.size() > 0 && $urandom_range(0, 2) == 0) begin
      pid = running[$urandom_range(0, running.size() - 1)];
      send_item(pfa_pkg::OP_HALT, 4'(pid), 20'($urandom()), 20'($urandom()));
    end else begin
      pid = $urandom_range(0, 15);
      send_item(pfa_pkg::OP_ADMIT, 4'(pid), seg_len(sb.pg_bytes), seg_len(sb.pg_bytes));
    end
  endtask

  // receiver
  initial begin
    int stall;
    frame_result_t r;
    out_ready = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (400) @(negedge clk);
      end else begin
        stall = burst ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          out_ready <= 0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      r.pid = out_process_echo;
      r.frame = out_frame_number;
      r.page = out_page_index;
      r.fill = out_fill_bytes;
      r.seg = out_segment_kind;
      r.freed = out_freed;
      r.status = out_status;
      r.last = out_last;
      sb.check(r);
      @(negedge clk);
    end
  end

  initial begin
    logic [20:0] mems[5];
    logic [15:0] pgs[5];
    mems = '{21'd1048576, 21'd16384, 21'd1048576, 21'd3000, 21'd64};
    pgs  = '{16'd16384, 16'd256, 16'd65535, 16'd1000, 16'd1};
    sb = new();
    burst = 0;
    hold_req = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = '0;
    in_valid = 0;
    in_opcode = 0;
    in_process_id = '0;
    in_text_bytes = '0;
    in_data_bytes = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // not configured, halt of an absent process
    send_item(pfa_pkg::OP_ADMIT, 4'd3, 20'd100, 20'd100);
    send_item(pfa_pkg::OP_HALT, 4'd3, 20'd0, 20'd0);
    // page size set but memory too small for a frame
    setup(21'd0, 16'd256);
    send_item(pfa_pkg::OP_ADMIT, 4'd0, 20'd1, 20'd1);
    setup(21'd1048576, 16'd16384);
    send_item(pfa_pkg::OP_ADMIT, 4'd0, 20'd1, 20'd1);
    send_item(pfa_pkg::OP_ADMIT, 4'd0, 20'd1, 20'd1);
    send_item(pfa_pkg::OP_ADMIT, 4'd1, 20'd0, 20'd5);
    send_item(pfa_pkg::OP_ADMIT, 4'd1, 20'd5, 20'd0);
    send_item(pfa_pkg::OP_ADMIT, 4'd2, 20'hFFFFF, 20'hFFFFF);
    send_item(pfa_pkg::OP_ADMIT, 4'd3, 20'd524288, 20'd524288);
    send_item(pfa_pkg::OP_HALT, 4'd0, 20'd0, 20'd0);
    send_item(pfa_pkg::OP_HALT, 4'd0, 20'd0, 20'd0);
    send_item(pfa_pkg::OP_ADMIT, 4'd0, 20'd507904, 20'd507904);
    send_item(pfa_pkg::OP_HALT, 4'd0, 20'd0, 20'd0);
    // exactly the page limit
    send_item(pfa_pkg::OP_ADMIT, 4'd15, 20'd524288, 20'd524288);
    send_item(pfa_pkg::OP_ADMIT, 4'd5, 20'd1, 20'd1);
    send_item(pfa_pkg::OP_HALT, 4'd15, 20'hFFFFF, 20'hFFFFF);
    setup(21'h1FFFFF, 16'hFFFF);
    send_item(pfa_pkg::OP_ADMIT, 4'd7, 20'hFFFFF, 20'd65535);
    send_item(pfa_pkg::OP_ADMIT, 4'd8, 20'd65536, 20'd1);
    send_item(pfa_pkg::OP_HALT, 4'd8, 20'd0, 20'd0);

    for (int ph = 0; ph < 5; ph++) begin
      setup(mems[ph], pgs[ph]);
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < 18; i++) begin
        if (i % 8 == 0) burst = ($urandom_range(0, 2) == 0);
        random_item();
      end
      burst = 0;
      if (ph == 2) drain();
    end

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("page_frame_allocator_top_tb: done, clean");
    else
      $display("page_frame_allocator_top_tb: done, errors");
    $finish;
  end

endmodule
